@@ hw/rtl/cmbe_pkg.sv @@
// package for the conditional multiply/branch execute block
// types and codes shared by the register file and the top level, and the condition check used by the top level
// no dependencies
`default_nettype none

package cmbe_pkg;

    // register file geometry
    localparam int unsigned NumRegs = 16;
    localparam int unsigned RegAw   = 4;
    localparam int unsigned DataW   = 32;
    localparam int unsigned OffW    = 24;

    // register 15 doubles as the program counter
    localparam logic [RegAw-1:0] PC_IDX = 4'd15;

    // flag bit positions in nzcv
    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_C = 1;
    localparam int unsigned FLAG_V = 0;

    // supported condition codes
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_GE = 4'ha;
    localparam logic [3:0] COND_LT = 4'hb;
    localparam logic [3:0] COND_GT = 4'hc;
    localparam logic [3:0] COND_LE = 4'hd;
    localparam logic [3:0] COND_AL = 4'he;

    typedef enum logic [1:0] {
        OP_MUL    = 2'd0,
        OP_BRANCH = 2'd1,
        OP_HALT   = 2'd2,
        OP_RSVD   = 2'd3
    } t_opcode;

    // register file write port
    typedef struct packed {
        logic             en;
        logic [RegAw-1:0] addr;
        logic [DataW-1:0] data;
    } t_rf_wr;

    // register file read request (pc port reads a fixed address)
    typedef struct packed {
        logic             en;
        logic [RegAw-1:0] rm;
        logic [RegAw-1:0] rs;
        logic [RegAw-1:0] rn;
    } t_rf_rd;

    // register file read data, available in the cycle after the request
    typedef struct packed {
        logic [DataW-1:0] rm;
        logic [DataW-1:0] rs;
        logic [DataW-1:0] rn;
        logic [DataW-1:0] pc;
    } t_rf_rdata;

    typedef struct packed {
        logic pass;
        logic bad;
    } t_cond_res;

    // condition code test against the current flags
    function automatic t_cond_res cond_check(input logic [3:0] cond, input logic [3:0] flags);
        logic      n;
        logic      z;
        logic      v;
        t_cond_res res;
        n        = flags[FLAG_N];
        z        = flags[FLAG_Z];
        v        = flags[FLAG_V];
        res.pass = 1'b0;
        res.bad  = 1'b0;
        case (cond)
            COND_EQ: res.pass = z;
            COND_NE: res.pass = !z;
            COND_GE: res.pass = (n == v);
            COND_LT: res.pass = (n != v);
            COND_GT: res.pass = !z && (n == v);
            COND_LE: res.pass = z || (n != v);
            COND_AL: res.pass = 1'b1;
            default: res.bad  = 1'b1;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cmbe_ram.sv @@
// generic synchronous ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module cmbe_ram #(
    parameter int unsigned Depth = 16,
    parameter int unsigned Width = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(Depth)-1:0] i_raddr0,
    input  wire logic [$clog2(Depth)-1:0] i_raddr1,
    output logic      [Width-1:0]         o_rdata0,
    output logic      [Width-1:0]         o_rdata1
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata0;
    logic [Width-1:0] r_rdata1;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, old data on a same-edge collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

`default_nettype wire

@@ hw/rtl/cmbe_regfile.sv @@
// register file: two mirrored ram copies giving four read ports, plus per-entry valid bits
// depends on cmbe_pkg and cmbe_ram
`default_nettype none

module cmbe_regfile (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cmbe_pkg::t_rf_rd      i_rd,
    input  wire cmbe_pkg::t_rf_wr      i_wr,
    output cmbe_pkg::t_rf_rdata        o_rdata
);

    import cmbe_pkg::*;

    logic [NumRegs-1:0] r_valid;
    logic               r_vld_rm;
    logic               r_vld_rs;
    logic               r_vld_rn;
    logic               r_vld_pc;
    logic [DataW-1:0]   ram_rm;
    logic [DataW-1:0]   ram_rs;
    logic [DataW-1:0]   ram_rn;
    logic [DataW-1:0]   ram_pc;

    // copy a serves rm and rs
    cmbe_ram #(
        .Depth(NumRegs),
        .Width(DataW)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd.en),
        .i_raddr0(i_rd.rm),
        .i_raddr1(i_rd.rs),
        .o_rdata0(ram_rm),
        .o_rdata1(ram_rs)
    );

    // copy b serves rn and the pc
    cmbe_ram #(
        .Depth(NumRegs),
        .Width(DataW)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd.en),
        .i_raddr0(i_rd.rn),
        .i_raddr1(PC_IDX),
        .o_rdata0(ram_rn),
        .o_rdata1(ram_pc)
    );

    // valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // valid bits follow the read data through the read register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_rm <= 1'b0;
            r_vld_rs <= 1'b0;
            r_vld_rn <= 1'b0;
            r_vld_pc <= 1'b0;
        end else if (i_rd.en) begin
            r_vld_rm <= r_valid[i_rd.rm];
            r_vld_rs <= r_valid[i_rd.rs];
            r_vld_rn <= r_valid[i_rd.rn];
            r_vld_pc <= r_valid[PC_IDX];
        end
    end

    assign o_rdata.rm = r_vld_rm ? ram_rm : '0;
    assign o_rdata.rs = r_vld_rs ? ram_rs : '0;
    assign o_rdata.rn = r_vld_rn ? ram_rn : '0;
    assign o_rdata.pc = r_vld_pc ? ram_pc : '0;

endmodule

`default_nettype wire

@@ hw/rtl/conditional_multiply_branch_execute.sv @@
// pipeline: a transaction is registered in the read stage, then the commit stage, then the output register
// throughput: one instruction per cycle while the output is not back-pressured; the read stage
//   stalls when its instruction reads a register that the instruction just ahead writes
//   (multiply destination or pc)
// reset: synchronous active low; clears control, flags and halt mark; the register file reads
//   zero through per-entry valid bits, so no clearing pass is needed
`default_nettype none

module conditional_multiply_branch_execute (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [3:0]                   i_condition,
    input  wire logic [cmbe_pkg::RegAw-1:0]   i_dest_reg,
    input  wire logic [cmbe_pkg::RegAw-1:0]   i_mult_reg,
    input  wire logic [cmbe_pkg::RegAw-1:0]   i_multiplier_reg,
    input  wire logic [cmbe_pkg::RegAw-1:0]   i_addend_reg,
    input  wire logic                         i_accumulate,
    input  wire logic                         i_set_flags,
    input  wire logic signed [cmbe_pkg::OffW-1:0] i_branch_offset,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_executed,
    output logic      [cmbe_pkg::DataW-1:0]   o_result_value,
    output logic      [3:0]                   o_flags_nzcv,
    output logic                              o_halted,
    output logic                              o_bad_condition
);

    import cmbe_pkg::*;

    // forward the newest matching write, else the ram data
    function automatic logic [DataW-1:0] fwd(input logic [RegAw-1:0] addr,
                                             input logic [DataW-1:0] ram,
                                             input t_rf_wr w1,
                                             input t_rf_wr w2);
        logic [DataW-1:0] val;
        val = ram;
        if (w2.en && (w2.addr == addr)) begin
            val = w2.data;
        end
        if (w1.en && (w1.addr == addr)) begin
            val = w1.data;
        end
        return val;
    endfunction

    // read stage
    logic              r_s1_v;
    t_opcode           r_s1_op;
    logic [3:0]        r_s1_cond;
    logic [RegAw-1:0]  r_s1_rd;
    logic [RegAw-1:0]  r_s1_rm;
    logic [RegAw-1:0]  r_s1_rs;
    logic [RegAw-1:0]  r_s1_rn;
    logic              r_s1_acc;
    logic              r_s1_sflag;
    logic [OffW-1:0]   r_s1_off;

    // commit stage
    logic              r_s2_v;
    t_opcode           r_s2_op;
    logic [3:0]        r_s2_cond;
    logic [RegAw-1:0]  r_s2_rd;
    logic              r_s2_acc;
    logic              r_s2_sflag;
    logic [OffW-1:0]   r_s2_off;
    logic [DataW-1:0]  r_s2_prod;
    logic [DataW-1:0]  r_s2_rn;
    logic [DataW-1:0]  r_s2_pc;

    // architectural flags and halt mark
    logic [3:0]        r_flags;
    logic              r_halt;

    // last two commits, for forwarding around the ram read latency
    t_rf_wr            r_w1;
    t_rf_wr            r_w2;

    // output register
    logic              r_ov;
    logic              r_o_exec;
    logic [DataW-1:0]  r_o_value;
    logic [3:0]        r_o_flags;
    logic              r_o_halt;
    logic              r_o_bad;

    t_rf_rd            rf_rd;
    t_rf_wr            rf_wr;
    t_rf_rdata         rf_rdata;

    logic              accept;
    logic              adv;
    logic              commit;
    logic              s2_free;
    logic              s1_move;
    logic              s1_free;
    logic              hazard;
    logic              s2_writes;
    logic [RegAw-1:0]  s2_waddr;
    logic              s1_reads;

    logic [DataW-1:0]  op_rm;
    logic [DataW-1:0]  op_rs;
    logic [DataW-1:0]  op_rn;
    logic [DataW-1:0]  op_pc;
    logic [DataW-1:0]  prod_full;

    t_cond_res         cres;
    logic              gated;
    logic              pass;
    logic              bad;
    logic [DataW-1:0]  mul_res;
    logic [DataW-1:0]  br_res;
    logic [DataW-1:0]  off_ext;
    logic [3:0]        n_flags;
    logic              n_halt;
    logic              n_exec;
    logic [DataW-1:0]  n_value;

    // register file
    cmbe_regfile u_regfile (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rd   (rf_rd),
        .i_wr   (rf_wr),
        .o_rdata(rf_rdata)
    );

    // pipeline handshake
    assign adv       = !r_ov || i_out_ready;
    assign commit    = r_s2_v && adv;
    assign s2_free   = !r_s2_v || adv;
    assign s2_writes = r_s2_v && ((r_s2_op == OP_MUL) || (r_s2_op == OP_BRANCH));
    assign s2_waddr  = (r_s2_op == OP_MUL) ? r_s2_rd : PC_IDX;

    // raw interlock against the instruction in the commit stage
    always_comb begin
        case (r_s1_op)
            OP_MUL: s1_reads = (r_s1_rm == s2_waddr) || (r_s1_rs == s2_waddr)
                               || (r_s1_acc && (r_s1_rn == s2_waddr));
            OP_BRANCH: s1_reads = (s2_waddr == PC_IDX);
            default: s1_reads = 1'b0;
        endcase
    end

    assign hazard     = r_s1_v && s2_writes && s1_reads;
    assign s1_move    = r_s1_v && !hazard && s2_free;
    assign s1_free    = !r_s1_v || s1_move;
    assign o_in_ready = s1_free;
    assign accept     = i_in_valid && s1_free;

    // register file read issued with the transaction
    assign rf_rd.en = accept;
    assign rf_rd.rm = i_mult_reg;
    assign rf_rd.rs = i_multiplier_reg;
    assign rf_rd.rn = i_addend_reg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_free) begin
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= t_opcode'(i_opcode);
            r_s1_cond  <= i_condition;
            r_s1_rd    <= i_dest_reg;
            r_s1_rm    <= i_mult_reg;
            r_s1_rs    <= i_multiplier_reg;
            r_s1_rn    <= i_addend_reg;
            r_s1_acc   <= i_accumulate;
            r_s1_sflag <= i_set_flags;
            r_s1_off   <= i_branch_offset;
        end
    end

    // operand forwarding and multiply, low word only
    assign op_rm     = fwd(r_s1_rm, rf_rdata.rm, r_w1, r_w2);
    assign op_rs     = fwd(r_s1_rs, rf_rdata.rs, r_w1, r_w2);
    assign op_rn     = fwd(r_s1_rn, rf_rdata.rn, r_w1, r_w2);
    assign op_pc     = fwd(PC_IDX, rf_rdata.pc, r_w1, r_w2);
    assign prod_full = op_rm * op_rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_free) begin
            r_s2_v <= s1_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_op    <= r_s1_op;
            r_s2_cond  <= r_s1_cond;
            r_s2_rd    <= r_s1_rd;
            r_s2_acc   <= r_s1_acc;
            r_s2_sflag <= r_s1_sflag;
            r_s2_off   <= r_s1_off;
            r_s2_prod  <= prod_full;
            r_s2_rn    <= op_rn;
            r_s2_pc    <= op_pc;
        end
    end

    // condition test, accumulate, branch target, flag update
    assign cres    = cond_check(r_s2_cond, r_flags);
    assign gated   = (r_s2_op == OP_MUL) || (r_s2_op == OP_BRANCH);
    assign pass    = gated && cres.pass;
    assign bad     = gated && cres.bad;
    assign mul_res = r_s2_prod + (r_s2_acc ? r_s2_rn : '0);
    assign off_ext = {{(DataW-OffW-2){r_s2_off[OffW-1]}}, r_s2_off, 2'b00};
    assign br_res  = r_s2_pc + off_ext;

    always_comb begin
        n_flags = r_flags;
        if (pass && (r_s2_op == OP_MUL) && r_s2_sflag) begin
            n_flags[FLAG_N] = mul_res[DataW-1];
            n_flags[FLAG_Z] = (mul_res == '0);
        end
        n_halt  = r_halt || (r_s2_op == OP_HALT);
        n_exec  = pass || (r_s2_op == OP_HALT);
        n_value = '0;
        if (pass) begin
            n_value = (r_s2_op == OP_MUL) ? mul_res : br_res;
        end
    end

    // write back
    assign rf_wr.en   = commit && pass;
    assign rf_wr.addr = s2_waddr;
    assign rf_wr.data = (r_s2_op == OP_MUL) ? mul_res : br_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_halt  <= 1'b0;
            r_w1    <= '0;
            r_w2    <= '0;
        end else if (commit) begin
            r_flags <= n_flags;
            r_halt  <= n_halt;
            r_w1    <= rf_wr;
            r_w2    <= r_w1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_o_exec  <= n_exec;
            r_o_value <= n_value;
            r_o_flags <= n_flags;
            r_o_halt  <= n_halt;
            r_o_bad   <= bad;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_executed      = r_o_exec;
    assign o_result_value  = r_o_value;
    assign o_flags_nzcv    = r_o_flags;
    assign o_halted        = r_o_halt;
    assign o_bad_condition = r_o_bad;

    // checks
    a_stall_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hazard && adv) |=> !hazard)
        else $error("interlock held for more than one cycle");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt mark cleared without reset");

    a_cv_untouched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (!r_flags[FLAG_C] && !r_flags[FLAG_V]))
        else $error("carry or overflow flag changed");

    a_exec_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_executed && o_bad_condition))
        else $error("transaction both executed and flagged bad condition");

endmodule

`default_nettype wire
